### rtl/core/qlt_pkg.sv
// qlt_pkg: shared constants, item codes and the queue entry type for the
// quoted line tokenizer. No dependencies.
package qlt_pkg;

  localparam int MAX_TOKENS     = 16;
  localparam int TOKEN_CAPACITY = 64;

  localparam int CH_W  = 8;
  localparam int IDX_W = 4;
  localparam int POS_W = 6;
  localparam int CNT_W = 5;
  localparam int LEN_W = 6;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // result item kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // special bytes
  localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CH_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;

  // one classified input word: an optional token item, then an optional done item
  typedef struct packed {
    logic             tok_v;
    logic [1:0]       tok_kind;
    logic [IDX_W-1:0] tok_idx;
    logic [POS_W-1:0] tok_pos;
    logic [CH_W-1:0]  tok_ch;
    logic             done_v;
    logic             done_status;
    logic [CNT_W-1:0] done_count;
  } qlt_entry_t;

endpackage

### rtl/core/quoted_line_tokenizer.sv
// quoted_line_tokenizer: top level of the line tokenizer stream block.
// Depends on qlt_pkg, qlt_front, qlt_fifo and qlt_back.
//
// Feeds one text line a byte per word on the in_ stream; a zero byte ends the
// line. Whitespace (9..13, 32) splits tokens, an unquoted '#' starts a comment
// to the line end, and a token opening with a double or single quote runs to
// the matching quote or the line end, keeping spaces and '#'. For every token
// byte the out_ stream gives a byte word (tuser 0) with token index and
// position, for every finished token an end word (tuser 1) with its length,
// and at the line end a done word (tuser 2) with the token count and status
// (1 = more than 16 tokens or a token of 64 bytes or more; the rest of the
// line is then dropped). One input word is taken per clock while the queue
// has room: the classifier settles each byte combinationally and pushes its
// result words as one entry into a four-entry queue, and the output side
// drains one word per clock while out_tready is high, so a result word is
// registered in the queue before it shows up on out_. Only a line end that
// closes an open token yields two words, sent one after the other; throughput
// is one byte per cycle except where such line ends come closer than the queue
// can absorb (lines of one or two short tokens). in_tready drops while the
// queue is full, i.e. when the result side stalls or two-word line ends pile
// up, and comes back the cycle after the queue drains an entry.
module quoted_line_tokenizer import qlt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] ch
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,   // [1:0] kind
  output logic [23:0] out_tdata    // [3:0] token_index, [9:4] char_position,
                                   // [17:10] char_out, [18] status,
                                   // [23:19] token_count
);

  logic       accept;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  qlt_entry_t push_entry;
  qlt_entry_t head_entry;

  logic [IDX_W-1:0] o_idx;
  logic [POS_W-1:0] o_pos;
  logic [CH_W-1:0]  o_ch;
  logic             o_status;
  logic [CNT_W-1:0] o_count;

  // take a word whenever the queue has room
  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  // classifier: tokenizer state and item generation
  qlt_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .ch    (in_tdata),
    .push  (push),
    .entry (push_entry)
  );

  // decoupling queue
  qlt_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .din  (push_entry),
    .pop  (pop),
    .dout (head_entry),
    .full (full),
    .empty(empty)
  );

  // result side: splits two-word entries
  qlt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_entry),
    .empty     (empty),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .o_idx     (o_idx),
    .o_pos     (o_pos),
    .o_ch      (o_ch),
    .o_status  (o_status),
    .o_count   (o_count)
  );

  assign out_tdata = {o_count, o_status, o_ch, o_pos, o_idx};

endmodule

### rtl/core/qlt_front.sv
// qlt_front: per-byte tokenizer state machine; turns each accepted input word
// into at most one queue entry. Depends on qlt_pkg.
module qlt_front import qlt_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [CH_W-1:0] ch,
  output logic            push,
  output qlt_entry_t      entry
);

  localparam logic [1:0] MODE_BETWEEN = 2'd0;
  localparam logic [1:0] MODE_PLAIN   = 2'd1;
  localparam logic [1:0] MODE_QUOTED  = 2'd2;
  localparam logic [1:0] MODE_COMMENT = 2'd3;

  logic [1:0]       mode_r, mode_nxt;
  logic             qsingle_r, qsingle_nxt;
  logic [CNT_W-1:0] done_r, done_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             err_r, err_nxt;

  logic            is_space;
  logic            is_hash;
  logic            is_quote;
  logic [CH_W-1:0] close_q;
  logic            do_store;
  logic            do_end;
  logic            tok_open;

  assign is_space = ch inside {[8'd9:8'd13], 8'd32};
  assign is_hash  = (ch == CH_HASH);
  assign is_quote = (ch == CH_DQUOTE) || (ch == CH_SQUOTE);
  assign close_q  = qsingle_r ? CH_SQUOTE : CH_DQUOTE;
  assign tok_open = (mode_r == MODE_PLAIN) || (mode_r == MODE_QUOTED);

  always_comb begin
    mode_nxt    = mode_r;
    qsingle_nxt = qsingle_r;
    done_nxt    = done_r;
    len_nxt     = len_r;
    err_nxt     = err_r;
    push        = 1'b0;
    entry       = '0;
    do_store    = 1'b0;
    do_end      = 1'b0;
    if (accept) begin
      if (ch == CH_NUL) begin
        push = 1'b1;
        if (!err_r && tok_open) begin
          entry.tok_v    = 1'b1;
          entry.tok_kind = KIND_END;
          entry.tok_idx  = done_r[IDX_W-1:0];
          entry.tok_pos  = len_r;
        end
        entry.done_v      = 1'b1;
        entry.done_status = err_r;
        entry.done_count  = done_r + CNT_W'(!err_r && tok_open);
        mode_nxt    = MODE_BETWEEN;
        qsingle_nxt = 1'b0;
        done_nxt    = '0;
        len_nxt     = '0;
        err_nxt     = 1'b0;
      end else if (!err_r && mode_r != MODE_COMMENT) begin
        case (mode_r)
          MODE_PLAIN: begin
            if (is_space || is_hash) do_end = 1'b1;
            else                     do_store = 1'b1;
          end
          MODE_QUOTED: begin
            if (ch == close_q) do_end = 1'b1;
            else               do_store = 1'b1;
          end
          default: begin
            if (is_space) begin
              mode_nxt = MODE_BETWEEN;
            end else if (is_hash) begin
              mode_nxt = MODE_COMMENT;
            end else if (done_r >= CNT_W'(MAX_TOKENS)) begin
              err_nxt = 1'b1;
            end else if (is_quote) begin
              mode_nxt    = MODE_QUOTED;
              qsingle_nxt = (ch == CH_SQUOTE);
              len_nxt     = '0;
            end else begin
              mode_nxt = MODE_PLAIN;
              do_store = 1'b1;
            end
          end
        endcase
        // len_r is zero between tokens, so a store opening a token lands at 0
        if (do_store) begin
          if ((LEN_W+1)'(len_r) + (LEN_W+1)'(1) >= (LEN_W+1)'(TOKEN_CAPACITY)) begin
            err_nxt = 1'b1;
          end else begin
            push           = 1'b1;
            entry.tok_v    = 1'b1;
            entry.tok_kind = KIND_BYTE;
            entry.tok_idx  = done_r[IDX_W-1:0];
            entry.tok_pos  = len_r;
            entry.tok_ch   = ch;
            len_nxt        = len_r + LEN_W'(1);
          end
        end
        if (do_end) begin
          push           = 1'b1;
          entry.tok_v    = 1'b1;
          entry.tok_kind = KIND_END;
          entry.tok_idx  = done_r[IDX_W-1:0];
          entry.tok_pos  = len_r;
          done_nxt       = done_r + CNT_W'(1);
          len_nxt        = '0;
          mode_nxt       = (mode_r == MODE_PLAIN && is_hash) ? MODE_COMMENT : MODE_BETWEEN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_BETWEEN;
      qsingle_r <= 1'b0;
      done_r    <= '0;
      len_r     <= '0;
      err_r     <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      qsingle_r <= qsingle_nxt;
      done_r    <= done_nxt;
      len_r     <= len_nxt;
      err_r     <= err_nxt;
    end
  end

  // never more completed tokens than allowed
  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r <= CNT_W'(MAX_TOKENS))
    else $error("token count beyond limit");

  // every pushed entry carries at least one result item
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (entry.tok_v || entry.done_v))
    else $error("empty entry pushed");

endmodule

### rtl/core/qlt_fifo.sv
// qlt_fifo: short flop queue between the classifier and the output side.
// Depends on qlt_pkg.
module qlt_fifo import qlt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  qlt_entry_t din,
  input  logic       pop,
  output qlt_entry_t dout,
  output logic       full,
  output logic       empty
);

  qlt_entry_t            mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_r, wr_nxt;
  logic [FIFO_PTR_W-1:0] rd_r, rd_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + FIFO_PTR_W'(1) : wr_r;
    rd_nxt  = pop  ? rd_r + FIFO_PTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("pop from empty queue");

endmodule

### rtl/core/qlt_back.sv
// qlt_back: drains queue entries onto the result stream, one or two words
// per entry. Depends on qlt_pkg.
module qlt_back import qlt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  qlt_entry_t        head,
  input  logic              empty,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [1:0]        out_tuser,
  output logic [IDX_W-1:0]  o_idx,
  output logic [POS_W-1:0]  o_pos,
  output logic [CH_W-1:0]   o_ch,
  output logic              o_status,
  output logic [CNT_W-1:0]  o_count
);

  logic phase_r, phase_nxt;   // token item of a two-word entry already sent
  logic sel_tok;
  logic fire;

  assign sel_tok    = head.tok_v && !phase_r;
  assign out_tvalid = !empty;
  assign fire       = out_tvalid && out_tready;
  assign pop        = fire && !(sel_tok && head.done_v);

  always_comb begin
    if (sel_tok) begin
      out_tuser = head.tok_kind;
      o_idx     = head.tok_idx;
      o_pos     = head.tok_pos;
      o_ch      = head.tok_ch;
      o_status  = 1'b0;
      o_count   = '0;
    end else begin
      out_tuser = KIND_DONE;
      o_idx     = '0;
      o_pos     = '0;
      o_ch      = '0;
      o_status  = head.done_status;
      o_count   = head.done_count;
    end
    phase_nxt = phase_r;
    if (fire) phase_nxt = !pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) phase_r <= 1'b0;
    else        phase_r <= phase_nxt;
  end

  // second half of an entry only while that entry is still at the head
  a_phase_valid: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (!empty && head.tok_v && head.done_v))
    else $error("stale second-word phase");

endmodule
